[src/plm_pkg.sv]
// shared types and constants for the piecewise-linear map
`default_nettype none

package plm_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_0 = 3'd4;

  // reset values of the breakpoint table, entry 0 first
  localparam logic [1:0] POINT_COUNT_RESET = 2'd3;
  localparam logic signed [DATA_W-1:0] IN_POINT_RESET [3] =
    '{-16'sd32768, 16'sd0, 16'sd32767};
  localparam logic signed [DATA_W-1:0] OUT_POINT_RESET [3] =
    '{-16'sd390, 16'sd0, 16'sd390};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_MULT,
    ST_DIV,
    ST_WRITE
  } plm_state_t;

  typedef struct packed {
    logic load;
    logic select;
    logic mult;
    logic div_step;
    logic write;
  } plm_cmd_t;

  typedef struct packed {
    logic early;
  } plm_status_t;

endpackage

`default_nettype wire

[src/plm_ctrl.sv]
// sequencing state machine and output valid for the piecewise-linear map
`default_nettype none

module plm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire                 m_tready,
  input  plm_pkg::plm_status_t status,
  output plm_pkg::plm_cmd_t    cmd
);

  plm_pkg::plm_state_t state;
  plm_pkg::plm_state_t state_next;
  logic [plm_pkg::DIV_CNT_W-1:0] cnt;
  logic [plm_pkg::DIV_CNT_W-1:0] cnt_next;
  logic                          m_tvalid_next;
  logic                          div_last;
  logic                          out_free;

  assign div_last = (cnt == plm_pkg::DIV_CNT_W'(plm_pkg::DIV_STEPS - 1));
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      plm_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = plm_pkg::ST_SELECT;
      end
      plm_pkg::ST_SELECT: begin
        state_next = status.early ? plm_pkg::ST_WRITE : plm_pkg::ST_MULT;
      end
      plm_pkg::ST_MULT: begin
        state_next = plm_pkg::ST_DIV;
      end
      plm_pkg::ST_DIV: begin
        if (div_last) state_next = plm_pkg::ST_WRITE;
      end
      plm_pkg::ST_WRITE: begin
        if (out_free) state_next = plm_pkg::ST_IDLE;
      end
      default: state_next = plm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    cnt_next = cnt;
    unique case (state)
      plm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      plm_pkg::ST_SELECT: begin
        cmd.select = 1'b1;
      end
      plm_pkg::ST_MULT: begin
        cmd.mult = 1'b1;
        cnt_next = '0;
      end
      plm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
      end
      plm_pkg::ST_WRITE: begin
        cmd.write = out_free;
      end
      default: ;
    endcase
  end

  // result register is full from the write until the receiver takes it
  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.write) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= plm_pkg::ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a sample is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == plm_pkg::ST_MULT) |=> (state == plm_pkg::ST_DIV && cnt == '0))
    else $error("division did not start from step zero");

endmodule

`default_nettype wire

[src/plm_datapath.sv]
// breakpoint registers, segment select, multiplier, serial divider, result
`default_nettype none

module plm_datapath #(
  parameter int unsigned MAX_POINTS = 3
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [plm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [plm_pkg::DATA_W-1:0]             cfg_data,
  input  wire  [plm_pkg::DATA_W-1:0]             sample_value,
  input  plm_pkg::plm_cmd_t                      cmd,
  output plm_pkg::plm_status_t                   status,
  output logic [plm_pkg::DATA_W-1:0]             mapped_value
);

  localparam int unsigned W = plm_pkg::DATA_W;

  logic [1:0]            point_count;
  logic signed [W-1:0]   in_pt  [MAX_POINTS];
  logic signed [W-1:0]   out_pt [MAX_POINTS];

  // three-entry view; entry 2 only matters when three points are in use
  logic signed [W-1:0]   in_v  [3];
  logic signed [W-1:0]   out_v [3];
  logic                  three_pt;

  logic signed [W-1:0]   x;
  logic signed [W-1:0]   base;
  logic [W-1:0]          dx;
  logic [W-1:0]          den;
  logic [W-1:0]          dy_mag;
  logic                  neg;
  logic                  early;
  logic [W-1:0]          rem;
  logic [W-1:0]          quo;

  logic                  sel_early;
  logic signed [W-1:0]   sel_base;
  logic signed [W-1:0]   lo_in, hi_in, lo_out, hi_out;
  logic signed [W:0]     dx_full, den_full, dy_full, dy_abs;
  logic [2*W-1:0]        product;
  logic [W:0]            shifted;
  logic [W+1:0]          trial;
  logic signed [W:0]     sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= plm_pkg::POINT_COUNT_RESET;
      for (int i = 0; i < MAX_POINTS; i++) begin
        in_pt[i]  <= plm_pkg::IN_POINT_RESET[i];
        out_pt[i] <= plm_pkg::OUT_POINT_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == plm_pkg::REG_POINT_COUNT) point_count <= cfg_data[1:0];
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index == plm_pkg::CFG_IDX_W'(plm_pkg::REG_IN_POINT_0 + i)) begin
          in_pt[i] <= cfg_data;
        end
        if (cfg_index == plm_pkg::CFG_IDX_W'(plm_pkg::REG_OUT_POINT_0 + i)) begin
          out_pt[i] <= cfg_data;
        end
      end
    end
  end

  assign three_pt = (MAX_POINTS > 2) && (point_count == 2'd3);

  always_comb begin
    in_v[0]  = in_pt[0];
    in_v[1]  = in_pt[1];
    in_v[2]  = in_pt[MAX_POINTS-1];
    out_v[0] = out_pt[0];
    out_v[1] = out_pt[1];
    out_v[2] = out_pt[MAX_POINTS-1];
  end

  // segment select: clamp at either end, exact hit on the inner point,
  // otherwise pick the segment and form its deltas
  always_comb begin
    lo_in  = in_v[0];
    lo_out = out_v[0];
    hi_in  = in_v[1];
    hi_out = out_v[1];
    if (three_pt && (x > in_v[1])) begin
      lo_in  = in_v[1];
      lo_out = out_v[1];
      hi_in  = in_v[2];
      hi_out = out_v[2];
    end
    sel_early = 1'b1;
    sel_base  = lo_out;
    if (x <= in_v[0]) begin
      sel_base = out_v[0];
    end else if (three_pt && (x >= in_v[2])) begin
      sel_base = out_v[2];
    end else if (!three_pt && (x >= in_v[1])) begin
      sel_base = out_v[1];
    end else if (three_pt && (x == in_v[1])) begin
      sel_base = out_v[1];
    end else begin
      sel_early = 1'b0;
    end
    dx_full  = {x[W-1], x} - {lo_in[W-1], lo_in};
    den_full = {hi_in[W-1], hi_in} - {lo_in[W-1], lo_in};
    dy_full  = {hi_out[W-1], hi_out} - {lo_out[W-1], lo_out};
    dy_abs   = dy_full[W] ? -dy_full : dy_full;
  end

  assign status.early = sel_early;

  assign product = dx * dy_mag;
  assign shifted = {rem, quo[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};
  assign sum     = {base[W-1], base} + (neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));

  always_ff @(posedge clk) begin
    if (cmd.load) x <= sample_value;
    if (cmd.select) begin
      early  <= sel_early;
      base   <= sel_base;
      dx     <= dx_full[W-1:0];
      den    <= den_full[W-1:0];
      dy_mag <= dy_abs[W-1:0];
      neg    <= dy_full[W];
    end
    // quotient fits in W bits since dx < den, so the high half starts as remainder
    if (cmd.mult) begin
      rem <= product[2*W-1:W];
      quo <= product[W-1:0];
    end else if (cmd.div_step) begin
      if (!trial[W+1]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
    if (cmd.write) mapped_value <= early ? base : sum[W-1:0];
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < den))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[src/piecewise_linear_map.sv]
// top level of the piecewise-linear map: stream ports, config port, wiring
//
// maps each signed 16-bit sample through a curve of two or three breakpoints
// held in configuration registers; below the first point the first output is
// given, above the last point the last output, between points the value is
// interpolated with the quotient truncated toward zero
// input channel s_*: one transaction per sample, tdata[15:0] = sample_value
// output channel m_*: one transaction per sample, tdata[15:0] = mapped_value
// config channel cfg_*: cfg_index picks the register (0 point count, 1..3
// input points, 4..6 output points), cfg_data carries its value; always ready,
// writes are meant to happen while no sample is in flight
// sequence: after the input transaction comes segment select; a sample inside
// a segment then passes the multiply and the 16-step restoring divider before
// the result write, one that clamps or hits a breakpoint goes straight to it
// flow: one sample at a time, taken only after the last one is written; the
// next sample is taken while a result still waits
// reset restores the default curve and empties the result register
// a stalled receiver holds the result; the block finishes the next sample and
// then waits with it until the result register is free
`default_nettype none

module piecewise_linear_map #(
  parameter int unsigned MAX_POINTS = 3
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [15:0]                  s_tdata,    // [15:0] sample_value
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [15:0]                  m_tdata,    // [15:0] mapped_value
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [plm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [15:0]                  cfg_data
);

  plm_pkg::plm_cmd_t    cmd;
  plm_pkg::plm_status_t status;

  // register file never stalls a config transaction
  assign cfg_ready = 1'b1;

  plm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  plm_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (s_tdata),
    .cmd          (cmd),
    .status       (status),
    .mapped_value (m_tdata)
  );

endmodule

`default_nettype wire

[dv/piecewise_linear_map_checker.sv]
// checker for the piecewise-linear map: curve copy, mapping prediction and comparison
module piecewise_linear_map_checker #(
  parameter int unsigned MAX_POINTS = 3
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  input  wire                            s_tready,
  input  wire  [15:0]                    s_tdata,
  input  wire                            m_tvalid,
  input  wire                            m_tready,
  input  wire  [15:0]                    m_tdata,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire  [plm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [15:0]                    cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    maps_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [plm_pkg::DATA_W-1:0] sample;
    logic signed [plm_pkg::DATA_W-1:0] mapped;
  } map_entry_t;

  map_entry_t expected_maps[$];

  logic [1:0]                        point_count_q;
  logic signed [plm_pkg::DATA_W-1:0] in_pt  [3];
  logic signed [plm_pkg::DATA_W-1:0] out_pt [3];

  function automatic logic signed [plm_pkg::DATA_W-1:0] interpolate_sample(
    input logic signed [plm_pkg::DATA_W-1:0] x
  );
    int     n;
    int     seg;
    longint num;
    longint den;
    longint y;
    n = point_count_q;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    // clamp tests come first, even for an unsorted curve
    if (x <= in_pt[0]) return out_pt[0];
    if (x >= in_pt[n-1]) return out_pt[n-1];
    seg = 1;
    while (seg < n - 1 && x > in_pt[seg]) seg++;
    if (x == in_pt[seg]) return out_pt[seg];
    num = (longint'(x) - longint'(in_pt[seg-1])) *
          (longint'(out_pt[seg]) - longint'(out_pt[seg-1]));
    den = longint'(in_pt[seg]) - longint'(in_pt[seg-1]);
    if (den == 0) return out_pt[seg-1];
    // sv division truncates toward zero
    y = num / den + longint'(out_pt[seg-1]);
    return y[plm_pkg::DATA_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    map_entry_t head;
    map_entry_t entry;
    if (rst) begin
      point_count_q = plm_pkg::POINT_COUNT_RESET;
      for (int k = 0; k < 3; k++) begin
        in_pt[k]  = plm_pkg::IN_POINT_RESET[k];
        out_pt[k] = plm_pkg::OUT_POINT_RESET[k];
      end
      expected_maps.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == plm_pkg::REG_POINT_COUNT) begin
          point_count_q = cfg_data[1:0];
        end else if (cfg_index >= plm_pkg::REG_IN_POINT_0 &&
                     cfg_index < plm_pkg::REG_OUT_POINT_0) begin
          in_pt[cfg_index - plm_pkg::REG_IN_POINT_0] = cfg_data;
        end else if (cfg_index >= plm_pkg::REG_OUT_POINT_0 &&
                     cfg_index < plm_pkg::REG_OUT_POINT_0 + 3) begin
          out_pt[cfg_index - plm_pkg::REG_OUT_POINT_0] = cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_maps.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result transaction: mapped_value %0d",
                     $signed(m_tdata));
          mismatch_count++;
        end else begin
          head = expected_maps.pop_front();
          if (m_tdata !== head.mapped) begin
            if (mismatch_count < 10)
              $display("mapped_value mismatch: sample %0d expected %0d got %0d",
                       head.sample, head.mapped, $signed(m_tdata));
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        entry.sample = s_tdata;
        entry.mapped = interpolate_sample(s_tdata);
        expected_maps.push_back(entry);
      end
    end
    maps_pending = expected_maps.size();
  end

endmodule

[dv/piecewise_linear_map_tb.sv]
// testbench top for the piecewise-linear map: clock, reset, stimulus and verdict
module piecewise_linear_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it, writes to it must change nothing
  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata = '0;      // [15:0] sample_value
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [15:0]                   m_tdata;           // [15:0] mapped_value
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [plm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned maps_pending;

  // stimulus-side copy of the curve, only used to aim samples at segments
  int curve_count = 3;
  int curve_in  [3] = '{-32768, 0, 32767};
  int curve_out [3] = '{-390, 0, 390};

  // sender burst state
  int burst_left = 0;
  bit gapless    = 1'b0;

  // long receiver hold-off, requested by the stimulus, counted by the receiver
  int hold_requests = 0;
  int hold_served   = 0;

  piecewise_linear_map i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  piecewise_linear_map_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .maps_pending   (maps_pending)
  );

  always #10 clk = ~clk;

  // receiver: switches between stall patterns, plus the long hold-off on request
  always @(negedge clk) begin : receiver
    static int mode      = 0;
    static int mode_left = 0;
    static int hold_left = 0;
    static int phase_cnt = 0;
    logic      ready;
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 3);
      mode_left = $urandom_range(1, 60);
    end
    mode_left--;
    phase_cnt++;
    case (mode)
      0: ready = 1'b1;                           // no stalls at all
      1: ready = ($urandom_range(0, 3) != 0);    // light stalls
      2: ready = ($urandom_range(0, 3) == 0);    // heavy stalls
      default: ready = (phase_cnt % 3 == 0);     // periodic
    endcase
    if (hold_left > 0) begin
      hold_left--;
      ready = 1'b0;
    end
    m_tready <= ready;
  end

  // one sample transaction, with a random gap before a new burst
  task automatic send_sample(input logic signed [15:0] sample);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop offering and wait for every expected mapping to come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (maps_pending != 0) @(negedge clk);
    // each sample gives a result, so a short settle is enough
    repeat (4) @(negedge clk);
  endtask

  // one config write transaction
  task automatic write_reg(input logic [plm_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // write all seven registers and keep the local copy in step
  task automatic program_curve(input int count, input int i0, input int i1,
                               input int i2, input int o0, input int o1,
                               input int o2);
    int ins  [3];
    int outs [3];
    ins  = '{i0, i1, i2};
    outs = '{o0, o1, o2};
    write_reg(plm_pkg::REG_POINT_COUNT, count);
    for (int k = 0; k < 3; k++) begin
      write_reg(plm_pkg::CFG_IDX_W'(plm_pkg::REG_IN_POINT_0 + k), ins[k]);
      write_reg(plm_pkg::CFG_IDX_W'(plm_pkg::REG_OUT_POINT_0 + k), outs[k]);
      curve_in[k]  = $signed(16'(ins[k]));
      curve_out[k] = $signed(16'(outs[k]));
    end
    curve_count = count & 3;
  endtask

  // random curve: mostly ascending points, sometimes crowded, sometimes unsorted
  task automatic random_curve();
    int pts  [3];
    int outs [3];
    int centre;
    int spread;
    int t;
    centre = int'($urandom_range(0, 65535)) - 32768;
    spread = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 64)) : 0;
    for (int k = 0; k < 3; k++) begin
      if (spread == 0) begin
        pts[k] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        t = centre + int'($urandom_range(0, 2 * spread)) - spread;
        pts[k] = (t > 32767) ? 32767 : (t < -32768) ? -32768 : t;
      end
      case ($urandom_range(0, 5))
        0: outs[k] = -32768;
        1: outs[k] = 32767;
        2: outs[k] = int'($urandom_range(0, 1000)) - 500;
        default: outs[k] = int'($urandom_range(0, 65535)) - 32768;
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      if (pts[0] > pts[1]) begin t = pts[0]; pts[0] = pts[1]; pts[1] = t; end
      if (pts[1] > pts[2]) begin t = pts[1]; pts[1] = pts[2]; pts[2] = t; end
      if (pts[0] > pts[1]) begin t = pts[0]; pts[0] = pts[1]; pts[1] = t; end
    end
    program_curve($urandom_range(0, 3), pts[0], pts[1], pts[2],
                  outs[0], outs[1], outs[2]);
  endtask

  // sample aimed mostly inside the curve, the rest at points, edges and noise
  function automatic logic signed [15:0] pick_sample();
    int n;
    int lo;
    int hi;
    int r;
    n  = (curve_count < 2) ? 2 : curve_count;
    lo = curve_in[0];
    hi = curve_in[n-1];
    r  = $urandom_range(0, 99);
    if (r < 55 && lo < hi)
      return 16'(lo + int'($urandom_range(0, hi - lo)));
    if (r < 75)
      return 16'(curve_in[$urandom_range(0, n - 1)] + int'($urandom_range(0, 2)) - 1);
    if (r < 92)
      return 16'($urandom_range(0, 65535));
    return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  initial begin : stimulus
    int wait_cycles;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default curve straight out of reset: clamps, centre point, both slopes
    send_sample(-16'sd32768);
    send_sample(-16'sd32767);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd16384);
    send_sample(16'sd32766);
    send_sample(16'sd32767);
    drain_results();

    // two points, full-scale falling output, write to the spare index as well
    program_curve(2, -1000, 2000, 5, 32767, -32768, 0);
    write_reg(REG_SPARE, 16'h1234);
    send_sample(-16'sd1000);
    send_sample(-16'sd999);
    send_sample(16'sd500);
    send_sample(16'sd1999);
    send_sample(16'sd2000);
    drain_results();

    // point count of zero and one behave as two
    write_reg(plm_pkg::REG_POINT_COUNT, 0);
    curve_count = 0;
    send_sample(16'sd0);
    send_sample(16'sd1500);
    drain_results();
    write_reg(plm_pkg::REG_POINT_COUNT, 1);
    curve_count = 1;
    send_sample(-16'sd500);
    send_sample(16'sd1998);
    drain_results();

    // unsorted input points still follow the same comparison order
    program_curve(3, 100, -200, 50, -300, 700, 1200);
    send_sample(16'sd75);
    send_sample(-16'sd100);
    send_sample(16'sd40);
    send_sample(16'sd100);
    drain_results();

    // widest possible segments and output swings
    program_curve(3, -32768, -32767, 32767, -32768, 32767, -32768);
    send_sample(-16'sd32767);
    send_sample(16'sd0);
    send_sample(16'sd32766);
    send_sample(-16'sd32768);
    drain_results();

    // random phases, each with its own curve and idling mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_curve();
      gapless = (p % 3 == 1);
      // receiver holds off while samples keep coming, so the block backs up
      if (p == 2) hold_requests++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_sample(pick_sample());
      drain_results();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (maps_pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && maps_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
src/plm_pkg.sv
src/plm_ctrl.sv
src/plm_datapath.sv
src/piecewise_linear_map.sv
dv/piecewise_linear_map_checker.sv
dv/piecewise_linear_map_tb.sv
